>>> rtl/velocity_slew_limiter_assert.svh
// assertion helpers for the slew limiter, clocked on aclk, off while in reset
`ifndef VELOCITY_SLEW_LIMITER_ASSERT_SVH
`define VELOCITY_SLEW_LIMITER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define VSL_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define VSL_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/vsl_pkg.sv
package vsl_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int CFG_W            = 15;
    localparam int CFG_INDEX_W      = 8;
    localparam int CFG_DATA_W       = 16;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_W-1:0]       cfg_val_t;

    // register indexes on the config port
    localparam cfg_index_t REG_MAX_SPEED    = cfg_index_t'(0);
    localparam cfg_index_t REG_MAX_STEP_XY  = cfg_index_t'(1);
    localparam cfg_index_t REG_MAX_STEP_Z   = cfg_index_t'(2);
    localparam cfg_index_t REG_MAX_STEP_YAW = cfg_index_t'(3);

    // register reset values, q5.10
    localparam cfg_val_t MAX_SPEED_RST    = cfg_val_t'(1536);
    localparam cfg_val_t MAX_STEP_XY_RST  = cfg_val_t'(20);
    localparam cfg_val_t MAX_STEP_Z_RST   = cfg_val_t'(12);
    localparam cfg_val_t MAX_STEP_YAW_RST = cfg_val_t'(31);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_NCHECK,
        ST_MULT,
        ST_DLOAD,
        ST_DIVIDE,
        ST_STORE,
        ST_XYPREP,
        ST_LIMIT
    } state_t;

    typedef enum logic {
        PASS_SPEED,
        PASS_STEP
    } pass_t;

endpackage

>>> rtl/velocity_slew_limiter.sv
// an accepted word runs the speed pass, then the horizontal pass unless it is the first word,
// a restart or max_step_xy is zero; a pass scales components only when its norm clamp bites
// one word at a time: s_tready low from accept until m_tvalid rises, a held result delays that
// the shared multiplier and subtractor set the pace: one root bit, one quotient bit per cycle
// reset: synchronous on aresetn low, registers back to defaults, history cleared
module velocity_slew_limiter #(
    parameter int  SAMPLE_WIDTH = vsl_pkg::SAMPLE_WIDTH_DEF,
    localparam int TDATA_W      = ((4 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // setpoint in
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [TDATA_W-1:0]            s_tdata,   // vel_north, vel_east, vel_down, yaw_rate
    input  logic                          s_tuser,   // restart
    // limited setpoint out
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [TDATA_W-1:0]            m_tdata,   // out_north, out_east, out_down, out_yawspeed
    // register writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  vsl_pkg::cfg_index_t           cfg_index,
    input  logic [vsl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import vsl_pkg::*;

    localparam int W       = SAMPLE_WIDTH;
    // magnitudes above 30 bits are pre-shifted so squares stay within the multiplier
    localparam int PS      = (W > 30) ? (W - 30) : 0;
    localparam int MAGW    = W - PS;
    localparam int SUMW    = 2 * MAGW + 1;
    localparam int SQ_ITER = MAGW + 1;
    localparam int MULBW   = (MAGW > CFG_W) ? MAGW : CFG_W;
    localparam int PW      = W + MULBW;
    localparam int SUBW    = (SUMW > W + 2) ? SUMW : (W + 2);
    localparam int CMPW    = (W + 1 > CFG_W) ? (W + 1) : CFG_W;
    localparam int CW      = ((W > CFG_W) ? W : CFG_W) + 2;
    localparam int CNT_MAX = (SQ_ITER > W) ? SQ_ITER : W;
    localparam int CNT_W   = $clog2(CNT_MAX);
    localparam logic [SUMW-1:0] ROOT_TOP = SUMW'(1) << (2 * MAGW);
    localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};

    // control state
    state_t           state_reg, state_next;
    pass_t            pass_reg, pass_next;
    logic [1:0]       idx_reg, idx_next;          // component under work
    logic [CNT_W-1:0] cnt_reg, cnt_next;          // root / divide step
    logic             primed_reg, primed_next;
    logic             restart_reg, restart_next;
    logic             m_valid_reg, m_valid_next;

    // config registers
    cfg_val_t max_speed_reg, max_speed_next;
    cfg_val_t max_step_xy_reg, max_step_xy_next;
    cfg_val_t max_step_z_reg, max_step_z_next;
    cfg_val_t max_step_yaw_reg, max_step_yaw_next;

    // history: last delivered setpoint
    logic signed [W-1:0] last_north_reg, last_north_next;
    logic signed [W-1:0] last_east_reg, last_east_next;
    logic signed [W-1:0] last_down_reg, last_down_next;
    logic signed [W-1:0] last_yaw_reg, last_yaw_next;

    // working setpoint
    logic signed [W-1:0] n_reg, n_next;
    logic signed [W-1:0] e_reg, e_next;
    logic signed [W-1:0] d_reg, d_next;
    logic signed [W-1:0] yaw_reg, yaw_next;

    // vector the norm and scale work on: velocity, then horizontal change
    logic signed [W:0]   op_reg [3];
    logic signed [W:0]   op_next [3];

    // shared arithmetic datapath
    logic [SUMW-1:0]     acc_reg, acc_next;       // sum of squares
    logic [PW-1:0]       prod_reg, prod_next;     // multiplier output
    logic [SUMW-1:0]     x_reg, x_next;           // root remainder
    logic [SUMW-1:0]     r_reg, r_next;           // root partial result
    logic [SUMW-1:0]     bit_reg, bit_next;       // root trial bit
    logic [W:0]          den_reg, den_next;       // norm, the divisor
    logic [W:0]          rem_reg, rem_next;       // divide remainder
    logic [W-1:0]        quo_reg, quo_next;       // dividend in, quotient out

    // output register
    logic signed [W-1:0] o_north_reg, o_north_next;
    logic signed [W-1:0] o_east_reg, o_east_next;
    logic signed [W-1:0] o_down_reg, o_down_next;
    logic signed [W-1:0] o_yaw_reg, o_yaw_next;

    // combinational helpers
    logic signed [W-1:0] in_n, in_e, in_d, in_yaw, yaw_neg;
    logic signed [W:0]   sel_op, sel_mag_full, q_ext, sq, last_sel, step_sum;
    logic [W-1:0]        sel_mag;
    logic [MAGW-1:0]     sel_smag;
    logic [W-1:0]        mul_a;
    logic [MULBW-1:0]    mul_b;
    logic [PW-1:0]       mul_p;
    logic [SUBW-1:0]     sub_a, sub_b;
    logic [SUBW:0]       diff;
    logic                ge;
    logic [SUMW-1:0]     acc_sum;
    logic [MAGW:0]       root;
    logic [W:0]          nrm;
    cfg_val_t            limit;
    logic                over_lim;
    logic [W+1:0]        sh;
    logic                last_comp;
    logic                step_en;
    logic                xy_go;
    logic                out_free;
    logic signed [CW-1:0] d_c, d_lo, d_hi, d_lim;
    logic signed [CW-1:0] y_c, y_lo, y_hi, y_lim;
    logic signed [CW-1:0] mz_ext, my_ext;

    // input word unpack
    assign in_n   = s_tdata[W-1:0];
    assign in_e   = s_tdata[2*W-1:W];
    assign in_d   = s_tdata[3*W-1:2*W];
    assign in_yaw = s_tdata[4*W-1:3*W];
    // clockwise yaw speed, the most negative rate saturates
    assign yaw_neg = (in_yaw == SMIN) ? SMAX : -in_yaw;

    // component select and magnitude
    assign sel_op       = (idx_reg == 2'd3) ? '0 : op_reg[idx_reg];
    assign sel_mag_full = sel_op[W] ? -sel_op : sel_op;
    assign sel_mag      = sel_mag_full[W-1:0];
    assign sel_smag     = MAGW'(sel_mag >> PS);

    // shared multiplier and subtractor
    assign mul_p = mul_a * mul_b;
    assign diff  = {1'b0, sub_a} - {1'b0, sub_b};
    assign ge    = !diff[SUBW];

    assign acc_sum = acc_reg + SUMW'(prod_reg[2*MAGW-1:0]);
    // ceiling root from floor root and remainder
    assign root    = r_reg[MAGW:0] + {{MAGW{1'b0}}, (x_reg != '0)};
    assign nrm     = (W + 1)'(root) << PS;
    assign limit   = (pass_reg == PASS_STEP) ? max_step_xy_reg : max_speed_reg;
    assign over_lim = CMPW'(nrm) > CMPW'(limit);

    assign sh        = {rem_reg, quo_reg[W-1]};
    assign q_ext     = $signed({1'b0, quo_reg});
    assign sq        = sel_op[W] ? -q_ext : q_ext;
    assign last_sel  = (idx_reg == 2'd0) ? (W + 1)'(last_north_reg) : (W + 1)'(last_east_reg);
    assign step_sum  = last_sel + sq;
    assign last_comp = (pass_reg == PASS_SPEED) ? (idx_reg == 2'd2) : (idx_reg == 2'd1);

    assign step_en  = primed_reg && !restart_reg;
    assign xy_go    = step_en && (max_step_xy_reg != '0);
    assign out_free = !m_valid_reg || m_tready;

    // per-tick clamps of down velocity and yaw speed
    assign mz_ext = CW'($signed({1'b0, max_step_z_reg}));
    assign my_ext = CW'($signed({1'b0, max_step_yaw_reg}));
    assign d_c    = CW'(d_reg);
    assign d_lo   = CW'(last_down_reg) - mz_ext;
    assign d_hi   = CW'(last_down_reg) + mz_ext;
    assign d_lim  = (d_c < d_lo) ? d_lo : ((d_c > d_hi) ? d_hi : d_c);
    assign y_c    = CW'(yaw_reg);
    assign y_lo   = CW'(last_yaw_reg) - my_ext;
    assign y_hi   = CW'(last_yaw_reg) + my_ext;
    assign y_lim  = (y_c < y_lo) ? y_lo : ((y_c > y_hi) ? y_hi : y_c);

    // ports
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = TDATA_W'({o_yaw_reg, o_down_reg, o_east_reg, o_north_reg});
    assign cfg_ready = 1'b1;

    // sequencer: next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_SQUARE;
            end
            ST_SQUARE: begin
                if (idx_reg == 2'd3) state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (cnt_reg == CNT_W'(SQ_ITER - 1)) state_next = ST_NCHECK;
            end
            ST_NCHECK: begin
                if (over_lim) begin
                    state_next = ST_MULT;
                end else if (pass_reg == PASS_SPEED) begin
                    state_next = ST_XYPREP;
                end else begin
                    state_next = ST_LIMIT;
                end
            end
            ST_MULT:  state_next = ST_DLOAD;
            ST_DLOAD: state_next = ST_DIVIDE;
            ST_DIVIDE: begin
                if (cnt_reg == CNT_W'(W - 1)) state_next = ST_STORE;
            end
            ST_STORE: begin
                if (!last_comp) begin
                    state_next = ST_MULT;
                end else if (pass_reg == PASS_SPEED) begin
                    state_next = ST_XYPREP;
                end else begin
                    state_next = ST_LIMIT;
                end
            end
            ST_XYPREP: begin
                state_next = xy_go ? ST_SQUARE : ST_LIMIT;
            end
            ST_LIMIT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer: datapath and outputs
    always_comb begin
        pass_next         = pass_reg;
        idx_next          = idx_reg;
        cnt_next          = cnt_reg;
        primed_next       = primed_reg;
        restart_next      = restart_reg;
        m_valid_next      = m_valid_reg;
        max_speed_next    = max_speed_reg;
        max_step_xy_next  = max_step_xy_reg;
        max_step_z_next   = max_step_z_reg;
        max_step_yaw_next = max_step_yaw_reg;
        last_north_next   = last_north_reg;
        last_east_next    = last_east_reg;
        last_down_next    = last_down_reg;
        last_yaw_next     = last_yaw_reg;
        n_next            = n_reg;
        e_next            = e_reg;
        d_next            = d_reg;
        yaw_next          = yaw_reg;
        op_next           = op_reg;
        acc_next          = acc_reg;
        prod_next         = prod_reg;
        x_next            = x_reg;
        r_next            = r_reg;
        bit_next          = bit_reg;
        den_next          = den_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        o_north_next      = o_north_reg;
        o_east_next       = o_east_reg;
        o_down_next       = o_down_reg;
        o_yaw_next        = o_yaw_reg;
        mul_a             = '0;
        mul_b             = '0;
        sub_a             = '0;
        sub_b             = '0;

        if (m_valid_reg && m_tready) m_valid_next = 1'b0;

        // register writes, unknown indexes dropped
        if (cfg_valid) begin
            case (cfg_index)
                REG_MAX_SPEED:    max_speed_next    = cfg_data[CFG_W-1:0];
                REG_MAX_STEP_XY:  max_step_xy_next  = cfg_data[CFG_W-1:0];
                REG_MAX_STEP_Z:   max_step_z_next   = cfg_data[CFG_W-1:0];
                REG_MAX_STEP_YAW: max_step_yaw_next = cfg_data[CFG_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    n_next       = in_n;
                    e_next       = in_e;
                    d_next       = in_d;
                    yaw_next     = yaw_neg;
                    restart_next = s_tuser;
                    op_next[0]   = (W + 1)'(in_n);
                    op_next[1]   = (W + 1)'(in_e);
                    op_next[2]   = (W + 1)'(in_d);
                    pass_next    = PASS_SPEED;
                    idx_next     = '0;
                    acc_next     = '0;
                    prod_next    = '0;
                end
            end
            ST_SQUARE: begin
                // square one component a cycle, accumulate the one before
                mul_a     = W'(sel_smag);
                mul_b     = MULBW'(sel_smag);
                prod_next = mul_p;
                acc_next  = acc_sum;
                idx_next  = idx_reg + 2'd1;
                if (idx_reg == 2'd3) begin
                    x_next   = acc_sum;
                    r_next   = '0;
                    bit_next = ROOT_TOP;
                    cnt_next = '0;
                    idx_next = '0;
                end
            end
            ST_ROOT: begin
                // digit-by-digit root, one result bit a cycle
                sub_a = SUBW'(x_reg);
                sub_b = SUBW'(r_reg | bit_reg);
                if (ge) begin
                    x_next = diff[SUMW-1:0];
                    r_next = (r_reg >> 1) | bit_reg;
                end else begin
                    r_next = r_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_NCHECK: begin
                den_next = nrm;
                idx_next = '0;
            end
            ST_MULT: begin
                mul_a     = sel_mag;
                mul_b     = MULBW'(limit);
                prod_next = mul_p;
            end
            ST_DLOAD: begin
                // quotient fits the sample width, so the upper part is below the divisor
                rem_next = (W + 1)'(prod_reg[W+CFG_W-1:W]);
                quo_next = prod_reg[W-1:0];
                cnt_next = '0;
            end
            ST_DIVIDE: begin
                // restoring divide, one quotient bit a cycle
                sub_a    = SUBW'(sh);
                sub_b    = SUBW'(den_reg);
                rem_next = ge ? diff[W:0] : sh[W:0];
                quo_next = {quo_reg[W-2:0], ge};
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_STORE: begin
                if (pass_reg == PASS_SPEED) begin
                    case (idx_reg)
                        2'd0:    n_next = sq[W-1:0];
                        2'd1:    e_next = sq[W-1:0];
                        default: d_next = sq[W-1:0];
                    endcase
                end else begin
                    if (idx_reg == 2'd0) begin
                        n_next = step_sum[W-1:0];
                    end else begin
                        e_next = step_sum[W-1:0];
                    end
                end
                idx_next = idx_reg + 2'd1;
            end
            ST_XYPREP: begin
                if (xy_go) begin
                    op_next[0] = (W + 1)'(n_reg) - (W + 1)'(last_north_reg);
                    op_next[1] = (W + 1)'(e_reg) - (W + 1)'(last_east_reg);
                    op_next[2] = '0;
                    pass_next  = PASS_STEP;
                    idx_next   = '0;
                    acc_next   = '0;
                    prod_next  = '0;
                end
            end
            ST_LIMIT: begin
                if (out_free) begin
                    o_north_next    = n_reg;
                    o_east_next     = e_reg;
                    o_down_next     = step_en ? d_lim[W-1:0] : d_reg;
                    o_yaw_next      = step_en ? y_lim[W-1:0] : yaw_reg;
                    last_north_next = n_reg;
                    last_east_next  = e_reg;
                    last_down_next  = step_en ? d_lim[W-1:0] : d_reg;
                    last_yaw_next   = step_en ? y_lim[W-1:0] : yaw_reg;
                    primed_next     = 1'b1;
                    m_valid_next    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            pass_reg         <= PASS_SPEED;
            idx_reg          <= '0;
            cnt_reg          <= '0;
            primed_reg       <= 1'b0;
            restart_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
            max_speed_reg    <= MAX_SPEED_RST;
            max_step_xy_reg  <= MAX_STEP_XY_RST;
            max_step_z_reg   <= MAX_STEP_Z_RST;
            max_step_yaw_reg <= MAX_STEP_YAW_RST;
            last_north_reg   <= '0;
            last_east_reg    <= '0;
            last_down_reg    <= '0;
            last_yaw_reg     <= '0;
        end else begin
            state_reg        <= state_next;
            pass_reg         <= pass_next;
            idx_reg          <= idx_next;
            cnt_reg          <= cnt_next;
            primed_reg       <= primed_next;
            restart_reg      <= restart_next;
            m_valid_reg      <= m_valid_next;
            max_speed_reg    <= max_speed_next;
            max_step_xy_reg  <= max_step_xy_next;
            max_step_z_reg   <= max_step_z_next;
            max_step_yaw_reg <= max_step_yaw_next;
            last_north_reg   <= last_north_next;
            last_east_reg    <= last_east_next;
            last_down_reg    <= last_down_next;
            last_yaw_reg     <= last_yaw_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        e_reg       <= e_next;
        d_reg       <= d_next;
        yaw_reg     <= yaw_next;
        op_reg      <= op_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        x_reg       <= x_next;
        r_reg       <= r_next;
        bit_reg     <= bit_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        o_north_reg <= o_north_next;
        o_east_reg  <= o_east_next;
        o_down_reg  <= o_down_next;
        o_yaw_reg   <= o_yaw_next;
    end

`include "velocity_slew_limiter_assert.svh"

    `VSL_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
    `VSL_ASSERT_NOW(a_rem_below_den, state_reg == ST_DIVIDE, rem_reg < den_reg, "divide remainder overflow")
    `VSL_ASSERT_NOW(a_root_count, state_reg == ST_ROOT, cnt_reg <= CNT_W'(SQ_ITER - 1), "root step count overrun")
    `VSL_ASSERT_NOW(a_valid_from_limit, $rose(m_valid_reg), $past(state_reg) == ST_LIMIT, "result not from limit step")

endmodule

>>> tb/sv/velocity_slew_limiter_test.sv
module velocity_slew_limiter_test;
    import vsl_pkg::*;

    // one setpoint word, first field in the lowest bits
    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [15:0] down;
        logic signed [15:0] east;
        logic signed [15:0] north;
    } setpoint_t;

    // predicts the limited setpoint for every accepted word and checks results in order
    class limiter_tracker;
        longint    speed_lim;
        longint    step_xy;
        longint    step_z;
        longint    step_yaw;
        bit        primed;
        longint    prev_n;
        longint    prev_e;
        longint    prev_d;
        longint    prev_yaw;
        setpoint_t expected_limited[$];
        int        failures;

        function new();
            speed_lim = longint'(MAX_SPEED_RST);
            step_xy   = longint'(MAX_STEP_XY_RST);
            step_z    = longint'(MAX_STEP_Z_RST);
            step_yaw  = longint'(MAX_STEP_YAW_RST);
            primed    = 1'b0;
            prev_n    = 0;
            prev_e    = 0;
            prev_d    = 0;
            prev_yaw  = 0;
            failures  = 0;
        endfunction

        // only the low 15 bits land in a register, unknown indexes are dropped
        function void write_register(cfg_index_t index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_MAX_SPEED:    speed_lim = longint'(data[CFG_W-1:0]);
                REG_MAX_STEP_XY:  step_xy   = longint'(data[CFG_W-1:0]);
                REG_MAX_STEP_Z:   step_z    = longint'(data[CFG_W-1:0]);
                REG_MAX_STEP_YAW: step_yaw  = longint'(data[CFG_W-1:0]);
                default: ;
            endcase
        endfunction

        // smallest r with r*r >= s
        function longint ceil_root(longint s);
            longint lo;
            longint hi;
            longint mid;
            lo = 0;
            hi = 131072;
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (mid * mid >= s) hi = mid;
                else lo = mid + 1;
            end
            return lo;
        endfunction

        // c * num / den, truncated toward zero
        function longint shrink(longint c, longint num, longint den);
            longint q;
            q = ((c < 0 ? -c : c) * num) / den;
            return c < 0 ? -q : q;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void note_setpoint(setpoint_t word, bit restart);
            longint    n;
            longint    e;
            longint    d;
            longint    yaw;
            longint    dn;
            longint    de;
            longint    len;
            setpoint_t lim;
            n   = longint'($signed(word.north));
            e   = longint'($signed(word.east));
            d   = longint'($signed(word.down));
            yaw = -longint'($signed(word.yaw));
            if (yaw > 32767) yaw = 32767;
            len = ceil_root(n * n + e * e + d * d);
            if (len > speed_lim) begin
                n = shrink(n, speed_lim, len);
                e = shrink(e, speed_lim, len);
                d = shrink(d, speed_lim, len);
            end
            if (primed && !restart) begin
                if (step_xy != 0) begin
                    dn  = n - prev_n;
                    de  = e - prev_e;
                    len = ceil_root(dn * dn + de * de);
                    if (len > step_xy) begin
                        n = prev_n + shrink(dn, step_xy, len);
                        e = prev_e + shrink(de, step_xy, len);
                    end
                end
                d   = clamp(d, prev_d - step_z, prev_d + step_z);
                yaw = clamp(yaw, prev_yaw - step_yaw, prev_yaw + step_yaw);
            end
            primed    = 1'b1;
            prev_n    = n;
            prev_e    = e;
            prev_d    = d;
            prev_yaw  = yaw;
            lim.north = n[15:0];
            lim.east  = e[15:0];
            lim.down  = d[15:0];
            lim.yaw   = yaw[15:0];
            expected_limited.push_back(lim);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0d, actual %0d", $time, name,
                         $signed(want), $signed(got));
                failures++;
            end
        endfunction

        function void check_limited(setpoint_t got);
            setpoint_t want;
            if (expected_limited.size() == 0) begin
                $display("%0t: result word with nothing expected, actual %h", $time, got);
                failures++;
                return;
            end
            want = expected_limited.pop_front();
            compare_field("out_north", want.north, got.north);
            compare_field("out_east", want.east, got.east);
            compare_field("out_down", want.down, got.down);
            compare_field("out_yawspeed", want.yaw, got.yaw);
        endfunction

        function int pending();
            return expected_limited.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [63:0]           s_tdata;   // vel_north, vel_east, vel_down, yaw_rate
    logic                  s_tuser;   // restart
    logic                  m_tvalid;
    logic                  m_tready;
    logic [63:0]           m_tdata;   // out_north, out_east, out_down, out_yawspeed
    logic                  cfg_valid;
    logic                  cfg_ready;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    limiter_tracker tracker;
    bit             steady;   // no idling on either side while set

    // trajectory cursor for well-formed random setpoints
    int cur_n;
    int cur_e;
    int cur_d;
    int cur_y;

    velocity_slew_limiter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 unit clock period
    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // hard stop in case a handshake never completes
    initial begin
        #8000000;
        $display("end of test: mismatches");
        $finish;
    end

    // result side: check every accepted word, stall now and then
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) tracker.check_limited(setpoint_t'(m_tdata));
            m_tready <= steady || ($urandom_range(0, 99) >= 6);
        end
    end

    // random gap before a word, valid dropped for each idle cycle
    task automatic idle_gap();
        if (!steady) begin
            while ($urandom_range(0, 99) < 6) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
    endtask

    // present one setpoint and hold it until accepted; valid stays high afterwards
    task automatic send_setpoint(int n, int e, int d, int y, bit restart);
        setpoint_t word;
        word.north = 16'(n);
        word.east  = 16'(e);
        word.down  = 16'(d);
        word.yaw   = 16'(y);
        idle_gap();
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= restart;
        do @(posedge aclk); while (!s_tready);
        tracker.note_setpoint(word, restart);
    endtask

    // stop sending and wait until every limited setpoint has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tracker.pending() != 0);
    endtask

    task automatic write_reg(cfg_index_t index, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        tracker.write_register(index, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // limit values: extremes, tight steps, mid range and anything
    function automatic logic [CFG_DATA_W-1:0] pick_limit();
        logic [CFG_DATA_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = 16'h7fff;
            2:       v = 16'($urandom_range(1, 64));
            3:       v = 16'($urandom_range(65, 4096));
            4:       v = 16'($urandom_range(1, 2048));
            default: v = 16'($urandom_range(0, 32767));
        endcase
        v[15] = 1'($urandom_range(0, 1));   // upper bit is dropped by the block
        return v;
    endfunction

    function automatic int wander(int v, int span);
        int w;
        w = v + int'($urandom_range(0, 2 * span)) - span;
        return w > 4096 ? 4096 : (w < -4096 ? -4096 : w);
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 5))
            0:       return -32768;
            1:       return -32767;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            default: return 32767;
        endcase
    endfunction

    // one random setpoint: mostly a smooth trajectory, some noise and extremes
    task automatic random_setpoint();
        int  kind;
        bit  restart;
        kind    = $urandom_range(0, 99);
        restart = ($urandom_range(0, 99) < 5);
        if (kind < 72) begin
            cur_n = wander(cur_n, 96);
            cur_e = wander(cur_e, 96);
            cur_d = wander(cur_d, 48);
            cur_y = wander(cur_y, 64);
            send_setpoint(cur_n, cur_e, cur_d, cur_y, restart);
        end else if (kind < 84) begin
            send_setpoint(int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
                          int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
                          restart);
        end else if (kind < 94) begin
            send_setpoint(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                          restart);
        end else begin
            // sudden jump inside the flight envelope
            cur_n = wander(0, 4096);
            cur_e = wander(0, 4096);
            cur_d = wander(0, 4096);
            cur_y = wander(0, 4096);
            send_setpoint(cur_n, cur_e, cur_d, cur_y, restart);
        end
    endtask

    initial begin
        tracker   = new;
        steady    = 1'b0;
        cur_n     = 0;
        cur_e     = 0;
        cur_d     = 0;
        cur_y     = 0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset limits: first word clamped by norm only, yaw rate at its most negative
        send_setpoint(32767, 32767, 32767, -32768, 1'b0);
        send_setpoint(-32768, -32768, -32768, 32767, 1'b0);
        send_setpoint(100, -50, 30, 10, 1'b0);
        send_setpoint(0, 0, 0, 0, 1'b0);
        // restart while primed starts the history over
        send_setpoint(500, 500, -500, 1000, 1'b1);
        send_setpoint(520, 490, -480, 990, 1'b0);
        drain();

        // widest speed limit, no horizontal limit, down and yaw frozen
        write_reg(REG_MAX_SPEED, 16'h7fff);
        write_reg(REG_MAX_STEP_XY, 16'h0000);
        write_reg(REG_MAX_STEP_Z, 16'h0000);
        write_reg(REG_MAX_STEP_YAW, 16'h0000);
        send_setpoint(-32768, 32767, 1000, -32768, 1'b0);
        send_setpoint(1234, -4321, -2000, 555, 1'b0);
        send_setpoint(0, 0, 0, -32768, 1'b1);
        drain();

        // zero speed squashes any nonzero vector; unknown indexes must not land
        write_reg(REG_MAX_SPEED, 16'h0000);
        write_reg(REG_MAX_STEP_XY, 16'h7fff);
        write_reg(REG_MAX_STEP_Z, 16'h7fff);
        write_reg(REG_MAX_STEP_YAW, 16'h7fff);
        write_reg(cfg_index_t'(4), 16'hffff);
        write_reg(cfg_index_t'(255), 16'hffff);
        send_setpoint(1, 0, 0, 5, 1'b0);
        send_setpoint(0, 0, 0, 0, 1'b0);
        send_setpoint(-32768, -1, 32767, 32767, 1'b0);
        drain();

        // tight steps, top data bit set on the speed write
        write_reg(REG_MAX_SPEED, 16'h8000 | 16'd4000);
        write_reg(REG_MAX_STEP_XY, 16'd7);
        write_reg(REG_MAX_STEP_Z, 16'd3);
        write_reg(REG_MAX_STEP_YAW, 16'd1);
        send_setpoint(1000, 0, 200, 300, 1'b1);
        send_setpoint(1100, 50, 250, 200, 1'b0);
        send_setpoint(1100, 50, 250, 200, 1'b0);
        send_setpoint(-1000, 2000, -300, -3000, 1'b0);
        send_setpoint(3000, 3000, 3000, 0, 1'b0);
        send_setpoint(3001, 2999, 2990, -5, 1'b0);
        drain();

        // random phases, each under fresh limits
        for (int phase = 0; phase < 6; phase++) begin
            write_reg(REG_MAX_SPEED, pick_limit());
            write_reg(REG_MAX_STEP_XY, pick_limit());
            write_reg(REG_MAX_STEP_Z, pick_limit());
            write_reg(REG_MAX_STEP_YAW, pick_limit());
            if ($urandom_range(0, 2) == 0)
                write_reg(cfg_index_t'($urandom_range(4, 255)), 16'($urandom_range(0, 65535)));
            steady = (phase == 2);   // one long stretch with no idling
            for (int k = 0; k < 117; k++) begin
                // now and then hold off until the block has caught up
                if ($urandom_range(0, 99) == 0) drain();
                random_setpoint();
            end
            drain();
            steady = 1'b0;
        end

        // latency margin for any stray result word
        repeat (160) @(posedge aclk);
        if (tracker.failures == 0 && tracker.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
